### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// shorthand for clocked assertions with async reset disable
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/lom_pkg.sv
// ---------------------------------------------------------------------------
// lom_pkg
// shared types and codes of the limit order matcher
// ---------------------------------------------------------------------------
package lom_pkg;

	localparam int MAX_RESULTS = 64;
	localparam int NW = $clog2(MAX_RESULTS + 1);

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_CANCEL = 1'b1;

	localparam logic [2:0] KIND_TRADE     = 3'd0;
	localparam logic [2:0] KIND_ADDED     = 3'd1;
	localparam logic [2:0] KIND_CANCELLED = 3'd2;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
	localparam logic [2:0] KIND_REJECT    = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic kill;
		logic fill;
		logic rest;
	} cmd_t;

endpackage

### rtl/lom_cell.sv
// ---------------------------------------------------------------------------
// lom_cell
// one book slot; folds its entry into the scan word passing down the row
// ---------------------------------------------------------------------------
module lom_cell #(
	parameter int MAX_ORDERS = 64,
	parameter int PRICE_BITS = 16,
	parameter int IDX = 0,
	localparam int IW = $clog2(MAX_ORDERS),
	localparam int SW = 4 + 3 * IW + 96 + PRICE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [SW-1:0]         scan_in,
	output logic [SW-1:0]         scan_out,
	input  lom_pkg::cmd_t         cmd,
	input  logic [IW-1:0]         wr_idx,
	input  logic [31:0]           wr_rem,
	input  logic [31:0]           key_id,
	input  logic                  aggr_sell,
	input  logic                  market,
	input  logic [PRICE_BITS-1:0] limit,
	input  logic [31:0]           counter
);
	import lom_pkg::*;

	typedef struct packed {
		logic                  vld;
		logic                  dup_hit;
		logic [IW-1:0]         dup_idx;
		logic                  free_hit;
		logic [IW-1:0]         free_idx;
		logic                  best_hit;
		logic [IW-1:0]         best_idx;
		logic [31:0]           best_id;
		logic [31:0]           best_rem;
		logic [PRICE_BITS-1:0] best_px;
		logic [31:0]           best_age;
	} scan_t;

	localparam logic [IW-1:0] ME = IW'(IDX);

	logic                  valid_q;
	logic [31:0]           id_q;
	logic                  sell_q;
	logic [PRICE_BITS-1:0] px_q;
	logic [31:0]           rem_q;
	logic [31:0]           arr_q;
	scan_t                 w_in;
	scan_t                 w_nx;
	scan_t                 w_q;
	logic [31:0]           age;
	logic                  elig;
	logic                  better;
	logic                  hit;

	assign w_in     = scan_in;
	assign scan_out = w_q;
	assign age      = counter - arr_q;
	assign hit      = (wr_idx == ME);

	always_comb begin
		elig = valid_q && (sell_q != aggr_sell) &&
			(market || (aggr_sell ? (px_q >= limit) : (px_q <= limit)));
		better = !w_in.best_hit ||
			(aggr_sell ? (px_q > w_in.best_px) : (px_q < w_in.best_px)) ||
			((px_q == w_in.best_px) && (age > w_in.best_age));
		w_nx = w_in;
		if (!w_in.dup_hit && valid_q && (id_q == key_id)) begin
			w_nx.dup_hit = 1'b1;
			w_nx.dup_idx = ME;
		end
		if (!w_in.free_hit && !valid_q) begin
			w_nx.free_hit = 1'b1;
			w_nx.free_idx = ME;
		end
		if (elig && better) begin
			w_nx.best_hit = 1'b1;
			w_nx.best_idx = ME;
			w_nx.best_id  = id_q;
			w_nx.best_rem = rem_q;
			w_nx.best_px  = px_q;
			w_nx.best_age = age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else begin
			w_q <= w_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hit) begin
			priority if (cmd.rest) begin
				valid_q <= 1'b1;
			end else if (cmd.kill) begin
				valid_q <= 1'b0;
			end else if (cmd.fill && (wr_rem == 32'd0)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && cmd.rest) begin
			id_q   <= key_id;
			sell_q <= aggr_sell;
			px_q   <= limit;
			rem_q  <= wr_rem;
			arr_q  <= counter;
		end else if (hit && cmd.fill) begin
			rem_q <= wr_rem;
		end
	end

endmodule

### rtl/limit_order_matcher.sv
// ---------------------------------------------------------------------------
// limit_order_matcher
// price-time priority order book built as a row of slot cells
// ---------------------------------------------------------------------------
//  channel   handshake          word
//  input     start / busy       op order_id side is_market price quantity
//  result    strobe (no stall)  kind resting_id aggressor_id fill_quantity
//                               fill_price rested dropped last
//
//  one scan of the cell row: launch, then the scan word ripples through every cell, decide as it leaves the last
//  a cancel takes one scan; an add takes one scan per trade plus one
//  reset clears every slot valid bit at once, no clearing pass
//  results come at most one per scan, strobe high one cycle, last on the final word
//  busy drops in the cycle the final word is shown
module limit_order_matcher #(
	parameter int MAX_ORDERS = 64,
	parameter int PRICE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [31:0] order_id,
	input  logic        side,
	input  logic        is_market,
	input  logic [15:0] price,
	input  logic [31:0] quantity,
	output logic        strobe,
	output logic [2:0]  kind,
	output logic [31:0] resting_id,
	output logic [31:0] aggressor_id,
	output logic [31:0] fill_quantity,
	output logic [15:0] fill_price,
	output logic        rested,
	output logic        dropped,
	output logic        last
);
	import lom_pkg::*;

	localparam int IW = $clog2(MAX_ORDERS);
	localparam int SW = 4 + 3 * IW + 96 + PRICE_BITS;

	typedef struct packed {
		logic                  vld;
		logic                  dup_hit;
		logic [IW-1:0]         dup_idx;
		logic                  free_hit;
		logic [IW-1:0]         free_idx;
		logic                  best_hit;
		logic [IW-1:0]         best_idx;
		logic [31:0]           best_id;
		logic [31:0]           best_rem;
		logic [PRICE_BITS-1:0] best_px;
		logic [31:0]           best_age;
	} scan_t;

	state_t                state_q, state_d;
	logic                  op_q;
	logic [31:0]           id_q;
	logic                  sell_q;
	logic                  mkt_q;
	logic [PRICE_BITS-1:0] lim_q;
	logic [31:0]           rem_q;
	logic [NW-1:0]         n_q;
	logic                  first_q;
	logic [31:0]           counter_q;
	logic                  pend_q;
	logic [31:0]           pend_rid_q;
	logic [31:0]           pend_qty_q;
	logic [PRICE_BITS-1:0] pend_px_q;

	logic [SW-1:0]         chain [MAX_ORDERS+1];
	scan_t                 head;
	scan_t                 tail;
	cmd_t                  cmd;
	logic [IW-1:0]         wr_idx;
	logic [31:0]           wr_rem;
	logic [31:0]           q;
	logic                  decide;
	logic                  do_trade;
	logic                  done;
	logic                  do_rest;
	logic                  do_drop;

	logic                  stb_d;
	logic [2:0]            kind_d;
	logic [31:0]           rid_d;
	logic [31:0]           aid_d;
	logic [31:0]           qty_d;
	logic [PRICE_BITS-1:0] px_d;
	logic                  rested_d;
	logic                  dropped_d;
	logic                  last_d;

	logic                  stb_q;
	logic [2:0]            kind_q;
	logic [31:0]           rid_q;
	logic [31:0]           aid_q;
	logic [31:0]           qty_q;
	logic [PRICE_BITS-1:0] px_q;
	logic                  rested_q;
	logic                  dropped_q;
	logic                  last_q;

	always_comb begin
		head     = '0;
		head.vld = (state_q == ST_LAUNCH);
	end
	assign chain[0] = head;
	assign tail     = chain[MAX_ORDERS];

	for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
		lom_cell #(
			.MAX_ORDERS(MAX_ORDERS),
			.PRICE_BITS(PRICE_BITS),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.scan_in(chain[i]),
			.scan_out(chain[i+1]),
			.cmd(cmd),
			.wr_idx(wr_idx),
			.wr_rem(wr_rem),
			.key_id(id_q),
			.aggr_sell(sell_q),
			.market(mkt_q),
			.limit(lim_q),
			.counter(counter_q)
		);
	end

	assign busy     = (state_q != ST_IDLE);
	assign decide   = (state_q == ST_SCAN) && tail.vld;
	assign q        = (rem_q < tail.best_rem) ? rem_q : tail.best_rem;
	assign do_trade = decide && (op_q == OP_ADD) && !(first_q && tail.dup_hit) &&
		(rem_q != 32'd0) && (n_q < NW'(MAX_RESULTS)) && tail.best_hit;
	assign done     = decide && !do_trade;
	assign do_rest  = (rem_q != 32'd0) && !mkt_q && tail.free_hit;
	assign do_drop  = (rem_q != 32'd0) && (mkt_q || !tail.free_hit);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LAUNCH;
			end
			ST_LAUNCH: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (do_trade) state_d = ST_LAUNCH;
				else if (done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		wr_idx    = tail.best_idx;
		wr_rem    = tail.best_rem - q;
		stb_d     = 1'b0;
		kind_d    = KIND_ADDED;
		rid_d     = '0;
		aid_d     = '0;
		qty_d     = '0;
		px_d      = '0;
		rested_d  = 1'b0;
		dropped_d = 1'b0;
		last_d    = 1'b0;
		if (decide) begin
			priority if (op_q == OP_CANCEL) begin
				stb_d  = 1'b1;
				last_d = 1'b1;
				wr_idx = tail.dup_idx;
				if (tail.dup_hit) begin
					cmd.kill = 1'b1;
					kind_d   = KIND_CANCELLED;
					rid_d    = id_q;
				end else begin
					kind_d = KIND_NOT_FOUND;
					aid_d  = id_q;
				end
			end else if (first_q && tail.dup_hit) begin
				stb_d  = 1'b1;
				last_d = 1'b1;
				kind_d = KIND_REJECT;
				aid_d  = id_q;
			end else if (do_trade) begin
				cmd.fill = 1'b1;
				stb_d    = pend_q;
				kind_d   = KIND_TRADE;
				rid_d    = pend_rid_q;
				aid_d    = id_q;
				qty_d    = pend_qty_q;
				px_d     = pend_px_q;
			end else begin
				cmd.rest  = do_rest;
				wr_idx    = tail.free_idx;
				wr_rem    = rem_q;
				stb_d     = 1'b1;
				last_d    = 1'b1;
				rested_d  = do_rest;
				dropped_d = do_drop;
				aid_d     = id_q;
				if (pend_q) begin
					kind_d = KIND_TRADE;
					rid_d  = pend_rid_q;
					qty_d  = pend_qty_q;
					px_d   = pend_px_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			counter_q <= '0;
			stb_q     <= 1'b0;
			pend_q    <= 1'b0;
			first_q   <= 1'b0;
			n_q       <= '0;
		end else begin
			state_q <= state_d;
			stb_q   <= stb_d;
			if (cmd.rest) counter_q <= counter_q + 32'd1;
			if (state_q == ST_IDLE && start) begin
				pend_q  <= 1'b0;
				first_q <= 1'b1;
				n_q     <= '0;
			end else if (decide) begin
				first_q <= 1'b0;
				if (do_trade) begin
					pend_q <= 1'b1;
					n_q    <= n_q + NW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q   <= op;
			id_q   <= order_id;
			sell_q <= side;
			mkt_q  <= is_market;
			lim_q  <= PRICE_BITS'(price);
			rem_q  <= quantity;
		end else if (do_trade) begin
			rem_q      <= rem_q - q;
			pend_rid_q <= tail.best_id;
			pend_qty_q <= q;
			pend_px_q  <= tail.best_px;
		end
		kind_q    <= kind_d;
		rid_q     <= rid_d;
		aid_q     <= aid_d;
		qty_q     <= qty_d;
		px_q      <= px_d;
		rested_q  <= rested_d;
		dropped_q <= dropped_d;
		last_q    <= last_d;
	end

	assign strobe        = stb_q;
	assign kind          = kind_q;
	assign resting_id    = rid_q;
	assign aggressor_id  = aid_q;
	assign fill_quantity = qty_q;
	assign fill_price    = 16'(px_q);
	assign rested        = rested_q;
	assign dropped       = dropped_q;
	assign last          = last_q;

endmodule

### rtl/lom_checker.sv
// ---------------------------------------------------------------------------
// lom_checker
// port-level checks of the limit order matcher
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lom_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        op,
	input logic [31:0] order_id,
	input logic        side,
	input logic        is_market,
	input logic [15:0] price,
	input logic [31:0] quantity,
	input logic        strobe,
	input logic [2:0]  kind,
	input logic [31:0] resting_id,
	input logic [31:0] aggressor_id,
	input logic [31:0] fill_quantity,
	input logic [15:0] fill_price,
	input logic        rested,
	input logic        dropped,
	input logic        last
);
	import lom_pkg::*;

	`AST_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`AST_IMP(a_last_frees, clk, arst_n, strobe && last, !busy)
	`AST_IMP(a_single_word, clk, arst_n, strobe && (kind != KIND_TRADE), last)
	`AST_IMP(a_flags_final, clk, arst_n, strobe && !last, !rested && !dropped)
	`AST_IMP(a_idle_quiet, clk, arst_n, strobe && !last, busy)

endmodule

bind limit_order_matcher lom_checker u_lom_checker (.*);

### verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// price-time priority order book: every accepted word is run through a
// behavioral book in the scoreboard and each strobed result word is compared
// field by field with the oldest expected one
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import lom_pkg::*;

typedef struct {
	logic [2:0]  kind;
	logic [31:0] resting_id;
	logic [31:0] aggressor_id;
	logic [31:0] fill_quantity;
	logic [15:0] fill_price;
	logic        rested;
	logic        dropped;
	logic        last;
} fill_report_t;

class match_board;
	localparam int DEPTH = 64;
	bit          live[DEPTH];
	logic [31:0] oid[DEPTH];
	bit          is_sell[DEPTH];
	logic [15:0] px[DEPTH];
	logic [31:0] left_qty[DEPTH];
	logic [31:0] arrival[DEPTH];
	logic [31:0] placed;
	fill_report_t due[$];
	int          errors;

	function new();
		foreach (live[i]) live[i] = 0;
		placed = 0;
		errors = 0;
	endfunction

	function int find_order(logic [31:0] id);
		for (int i = 0; i < DEPTH; i++)
			if (live[i] && oid[i] == id) return i;
		return -1;
	endfunction

	function int best_match(bit sell, bit mkt, logic [15:0] lim);
		int b;
		logic [15:0] p;
		b = -1;
		for (int i = 0; i < DEPTH; i++) begin
			if (!live[i] || is_sell[i] == sell) continue;
			p = px[i];
			if (!mkt && !sell && p > lim) continue;
			if (!mkt && sell && p < lim) continue;
			if (b < 0) begin
				b = i;
			end else if (sell ? (p > px[b]) : (p < px[b])) begin
				b = i;
			end else if (p == px[b]) begin
				if (32'(placed - arrival[i]) > 32'(placed - arrival[b])) b = i;
			end
		end
		return b;
	endfunction

	function void push(logic [2:0] k, logic [31:0] rid, logic [31:0] aid,
			logic [31:0] q, logic [15:0] p, bit r, bit d, bit l);
		fill_report_t e;
		e.kind = k; e.resting_id = rid; e.aggressor_id = aid;
		e.fill_quantity = q; e.fill_price = p;
		e.rested = r; e.dropped = d; e.last = l;
		due.insert(due.size(), e);
	endfunction

	function void note(logic o, logic [31:0] id, bit sell, bit mkt, logic [15:0] lim,
			logic [31:0] qty);
		int s, n;
		logic [31:0] q, rem;
		bit r, d;
		n = 0; r = 0; d = 0; rem = qty;
		if (o == OP_CANCEL) begin
			s = find_order(id);
			if (s < 0) begin
				push(KIND_NOT_FOUND, 0, id, 0, 0, 0, 0, 1);
			end else begin
				live[s] = 0;
				push(KIND_CANCELLED, id, 0, 0, 0, 0, 0, 1);
			end
			return;
		end
		if (find_order(id) >= 0) begin
			push(KIND_REJECT, 0, id, 0, 0, 0, 0, 1);
			return;
		end
		while (rem != 0 && n < MAX_RESULTS) begin
			s = best_match(sell, mkt, lim);
			if (s < 0) break;
			q = rem < left_qty[s] ? rem : left_qty[s];
			push(KIND_TRADE, oid[s], id, q, px[s], 0, 0, 0);
			n++;
			rem -= q;
			left_qty[s] -= q;
			if (left_qty[s] == 0) live[s] = 0;
		end
		if (rem != 0) begin
			if (mkt) begin
				d = 1;
			end else begin
				s = -1;
				for (int i = 0; i < DEPTH; i++)
					if (!live[i]) begin
						s = i;
						break;
					end
				if (s < 0) begin
					d = 1;
				end else begin
					live[s] = 1; oid[s] = id; is_sell[s] = sell; px[s] = lim;
					left_qty[s] = rem; arrival[s] = placed;
					placed++;
					r = 1;
				end
			end
		end
		if (n == 0) begin
			push(KIND_ADDED, 0, id, 0, 0, r, d, 1);
		end else begin
			due[$].rested = r;
			due[$].dropped = d;
			due[$].last = 1;
		end
	endfunction

	function void cmp(string f, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%t %s expected %h actual %h", $realtime, f, e, a);
			errors++;
		end
	endfunction

	function void check(fill_report_t a);
		fill_report_t e;
		if (due.size() == 0) begin
			$display("%t unexpected result word kind %0d actual id %h", $realtime,
				a.kind, a.aggressor_id);
			errors++;
			return;
		end
		e = due[0];
		due.delete(0);
		cmp("kind", 32'(e.kind), 32'(a.kind));
		cmp("resting_id", e.resting_id, a.resting_id);
		cmp("aggressor_id", e.aggressor_id, a.aggressor_id);
		cmp("fill_quantity", e.fill_quantity, a.fill_quantity);
		cmp("fill_price", 32'(e.fill_price), 32'(a.fill_price));
		cmp("rested", 32'(e.rested), 32'(a.rested));
		cmp("dropped", 32'(e.dropped), 32'(a.dropped));
		cmp("last", 32'(e.last), 32'(a.last));
	endfunction
endclass

module tb_top;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic        op = 0;
	logic [31:0] order_id = 0;
	logic        side = 0;
	logic        is_market = 0;
	logic [15:0] price = 0;
	logic [31:0] quantity = 0;
	logic        strobe;
	logic [2:0]  kind;
	logic [31:0] resting_id;
	logic [31:0] aggressor_id;
	logic [31:0] fill_quantity;
	logic [15:0] fill_price;
	logic        rested;
	logic        dropped;
	logic        last;

	match_board  board = new();
	int          idle_pct;
	logic [31:0] next_id;

	limit_order_matcher dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		fill_report_t a;
		if (arst_n && strobe) begin
			a.kind = kind; a.resting_id = resting_id; a.aggressor_id = aggressor_id;
			a.fill_quantity = fill_quantity; a.fill_price = fill_price;
			a.rested = rested; a.dropped = dropped; a.last = last;
			board.check(a);
		end
	end

	task send_word(logic o, logic [31:0] id, bit sd, bit mkt, logic [15:0] p,
			logic [31:0] q);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1; op <= o; order_id <= id; side <= sd;
		is_market <= mkt; price <= p; quantity <= q;
		do @(posedge clk); while (busy);
		board.note(o, id, sd, mkt, p, q);
		@(negedge clk);
	endtask

	task random_word();
		logic [31:0] id, q;
		logic [15:0] p;
		id = next_id;
		if ($urandom_range(9) == 0) id = $urandom;
		else if ($urandom_range(4) == 0) id = next_id - $urandom_range(1, 30);
		else next_id++;
		p = 16'd1000 + 16'($urandom_range(20));
		if ($urandom_range(9) == 0) p = 16'($urandom);
		q = $urandom_range(1, 50);
		case ($urandom_range(19))
			0: q = 0;
			1: q = $urandom;
			default: ;
		endcase
		if ($urandom_range(3) == 0)
			send_word(OP_CANCEL, next_id - $urandom_range(0, 40), 1'($urandom),
				1'($urandom), 16'($urandom), $urandom);
		else
			send_word(OP_ADD, id, 1'($urandom), $urandom_range(9) == 0, p, q);
	endtask

	task sweep();
		bit sd;
		int cnt;
		sd = 1'($urandom);
		cnt = $urandom_range(60, 70);
		repeat (cnt) begin
			send_word(OP_ADD, next_id, sd, 0, 16'd1000 + 16'($urandom_range(20)),
				$urandom_range(1, 5));
			next_id++;
		end
		send_word(OP_ADD, next_id, !sd, 1, 16'($urandom), 32'hFFFF_FFFF);
		next_id++;
	endtask

	task drain();
		start <= 0;
		while (board.due.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	initial begin
		idle_pct = 0;
		next_id = 1000;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed
		send_word(OP_CANCEL, 32'd0, 1, 1, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_ADD, 32'd1, 0, 0, 16'd0, 32'd1);
		send_word(OP_ADD, 32'hFFFF_FFFF, 1, 0, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_ADD, 32'd1, 1, 0, 16'd5, 32'd9);
		send_word(OP_ADD, 32'd2, 1, 0, 16'd0, 32'd5);
		send_word(OP_ADD, 32'd3, 0, 1, 16'd0, 32'd3);
		send_word(OP_ADD, 32'd4, 0, 0, 16'd7, 32'd0);
		send_word(OP_CANCEL, 32'd2, 0, 0, 16'd0, 32'd0);
		send_word(OP_CANCEL, 32'd2, 0, 0, 16'd0, 32'd0);
		send_word(OP_ADD, 32'd5, 1, 1, 16'd0, 32'd4);
		send_word(OP_ADD, 32'd6, 1, 0, 16'd100, 32'd3);
		send_word(OP_ADD, 32'd7, 1, 0, 16'd100, 32'd3);
		send_word(OP_ADD, 32'd9, 1, 0, 16'd99, 32'd1);
		send_word(OP_ADD, 32'd8, 0, 0, 16'd100, 32'd10);
		send_word(OP_ADD, 32'd10, 1, 1, 16'hFFFF, 32'd20);
		send_word(OP_CANCEL, 32'd8, 0, 0, 16'd0, 32'd0);
		send_word(OP_CANCEL, 32'hFFFF_FFFF, 0, 0, 16'd0, 32'd0);
		send_word(OP_ADD, 32'h8000_0000, 0, 1, 16'hFFFF, 32'h8000_0000);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 24 : (ph == 1) ? 45 : 0;
			repeat (35) random_word();
			sweep();
			repeat (35) random_word();
			if (ph == 1) drain();
		end

		drain();
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#200ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
